/* src/cpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned KindW         = 3;
  localparam int unsigned RowIdxW       = 16;
  localparam int unsigned CountW        = 17;
  localparam int unsigned CountMax      = (2 ** CountW) - 1;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned MaxRowsDefault = 65536;
  localparam int unsigned FifoDepth     = 4;
  localparam int unsigned FifoPtrW      = $clog2(FifoDepth);
  localparam int unsigned FifoCntW      = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_COMPARE_KIND = 2'd0,
    REG_TARGET_VALUE = 2'd1
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    CMP_EQ = 3'd0,
    CMP_GT = 3'd1,
    CMP_GE = 3'd2,
    CMP_LT = 3'd3,
    CMP_LE = 3'd4
  } cmp_kind_e;

  typedef struct packed {
    logic               is_total;
    logic [RowIdxW-1:0] match_row;
    logic [CountW-1:0]  total_matches;
    logic               end_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

/* src/column_predicate_filter_top.sv */
// column predicate filter
// input channel: one row per transfer (row_value_i, row_deleted_i, last_row_i)
//   under in_valid_i / in_stall_o
// output channel: result transfers under out_valid_o / out_stall_i; a matching
//   row gives its row index, and the row marked last is followed by a total
//   result carrying the match count of the block
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i (0 compare kind,
//   1 target value) and cfg_data_i; ready is always high, write only when idle
// path: a row is held in the row register, then its results are written to
//   the result queue, which drives the output channel
// throughput: one row per cycle; the row register hands on a row only when
//   the four-entry result queue has two free entries, so a last row that also
//   matches needs two output transfers and the queue drain sets the rate
// reset: counters, the queue and both config registers clear at once
// a stall on the output fills the queue, then the row register, then raises
//   in_stall_o; nothing is dropped
`timescale 1ns / 1ps
`default_nettype none

module column_predicate_filter_top #(
  parameter int unsigned MAX_ROWS = cpf_pkg::MaxRowsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [cpf_pkg::ValueW-1:0] row_value_i,
  input  logic                              row_deleted_i,
  input  logic                              last_row_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              is_total_o,
  output logic [cpf_pkg::RowIdxW-1:0]       match_row_o,
  output logic [cpf_pkg::CountW-1:0]        total_matches_o,
  output logic                              end_of_run_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cpf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [cpf_pkg::ValueW-1:0]        cfg_data_i
);

  logic [cpf_pkg::KindW-1:0]         kind_q;
  logic signed [cpf_pkg::ValueW-1:0] target_q;
  logic                              row_valid_q, row_valid_d;
  logic signed [cpf_pkg::ValueW-1:0] value_q;
  logic                              deleted_q, last_q;
  logic                              in_fire, row_fire, room, match;
  cpf_pkg::push_t                    push, push_gated;
  cpf_pkg::result_t                  res;

  assign cfg_ready_o = 1'b1;
  assign row_fire    = row_valid_q && room;
  assign in_stall_o  = row_valid_q && !room;
  assign in_fire     = in_valid_i && !in_stall_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= '0;
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cpf_pkg::REG_COMPARE_KIND: kind_q   <= cfg_data_i[cpf_pkg::KindW-1:0];
        cpf_pkg::REG_TARGET_VALUE: target_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // row register
  always_comb begin
    row_valid_d = row_valid_q;
    if (in_fire) begin
      row_valid_d = 1'b1;
    end else if (row_fire) begin
      row_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= 1'b0;
    end else begin
      row_valid_q <= row_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      value_q   <= row_value_i;
      deleted_q <= row_deleted_i;
      last_q    <= last_row_i;
    end
  end

  cpf_compare u_compare (
    .kind_i    (kind_q),
    .target_i  (target_q),
    .value_i   (value_q),
    .deleted_i (deleted_q),
    .match_o   (match)
  );

  cpf_count #(
    .MAX_ROWS (MAX_ROWS)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (row_fire),
    .match_i (match),
    .last_i  (last_q),
    .push_o  (push)
  );

  always_comb begin
    push_gated = push;
    if (!row_fire) begin
      push_gated.num = 2'd0;
    end
  end

  cpf_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_gated),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res)
  );

  assign is_total_o      = res.is_total;
  assign match_row_o     = res.match_row;
  assign total_matches_o = res.total_matches;
  assign end_of_run_o    = res.end_of_run;

endmodule

`default_nettype wire

/* src/cpf_compare.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpf_compare (
  input  logic [cpf_pkg::KindW-1:0]         kind_i,
  input  logic signed [cpf_pkg::ValueW-1:0] target_i,
  input  logic signed [cpf_pkg::ValueW-1:0] value_i,
  input  logic                              deleted_i,
  output logic                              match_o
);

  logic pass;

  always_comb begin
    unique case (kind_i)
      cpf_pkg::CMP_EQ: pass = (value_i == target_i);
      cpf_pkg::CMP_GT: pass = (value_i > target_i);
      cpf_pkg::CMP_GE: pass = (value_i >= target_i);
      cpf_pkg::CMP_LT: pass = (value_i < target_i);
      cpf_pkg::CMP_LE: pass = (value_i <= target_i);
      default:         pass = 1'b0;
    endcase
  end

  assign match_o = pass && !deleted_i;

endmodule

`default_nettype wire

/* src/cpf_count.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpf_count #(
  parameter int unsigned MAX_ROWS = cpf_pkg::MaxRowsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic            match_i,
  input  logic            last_i,
  output cpf_pkg::push_t  push_o
);

  localparam int unsigned RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned MatchCap =
      (MAX_ROWS < cpf_pkg::CountMax) ? MAX_ROWS : cpf_pkg::CountMax;

  logic [RowW-1:0]                 row_q, row_d;
  logic [cpf_pkg::CountW-1:0]      match_q, match_d, match_inc;
  logic [RowW+cpf_pkg::RowIdxW-1:0] row_ext;
  cpf_pkg::result_t                match_res, total_res;

  assign row_ext = {{cpf_pkg::RowIdxW{1'b0}}, row_q};

  always_comb begin
    match_inc = match_q;
    if (match_i && (match_q < cpf_pkg::CountW'(MatchCap))) begin
      match_inc = match_q + cpf_pkg::CountW'(1);
    end

    match_res.is_total      = 1'b0;
    match_res.match_row     = row_ext[cpf_pkg::RowIdxW-1:0];
    match_res.total_matches = '0;
    match_res.end_of_run    = !last_i;

    total_res.is_total      = 1'b1;
    total_res.match_row     = '0;
    total_res.total_matches = match_inc;
    total_res.end_of_run    = 1'b1;

    push_o.num    = {1'b0, match_i} + {1'b0, last_i};
    push_o.first  = match_i ? match_res : total_res;
    push_o.second = total_res;
  end

  always_comb begin
    row_d   = row_q;
    match_d = match_q;
    if (fire_i) begin
      if (last_i) begin
        row_d   = '0;
        match_d = '0;
      end else begin
        match_d = match_inc;
        if (row_q == RowW'(MAX_ROWS - 1)) begin
          row_d = '0;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      match_q <= '0;
    end else begin
      row_q   <= row_d;
      match_q <= match_d;
    end
  end

endmodule

`default_nettype wire

/* src/cpf_result_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpf_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpf_pkg::push_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             stall_i,
  output cpf_pkg::result_t data_o
);

  cpf_pkg::result_t                mem_q [cpf_pkg::FifoDepth];
  logic [cpf_pkg::FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q, wr_next;
  logic [cpf_pkg::FifoCntW-1:0]    count_q;
  logic                            pop;

  assign room_o  = (count_q <= cpf_pkg::FifoCntW'(cpf_pkg::FifoDepth - 2));
  assign valid_o = (count_q != '0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign wr_next = wr_ptr_q + cpf_pkg::FifoPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + cpf_pkg::FifoPtrW'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + cpf_pkg::FifoPtrW'(1);
      end
      count_q <= count_q + cpf_pkg::FifoCntW'(push_i.num)
               - cpf_pkg::FifoCntW'(pop);
    end
  end

endmodule

`default_nettype wire

/* src/cpf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpf_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic                        is_total_o,
  input  logic [cpf_pkg::RowIdxW-1:0] match_row_o,
  input  logic [cpf_pkg::CountW-1:0]  total_matches_o,
  input  logic                        end_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_total_o)
      && $stable(match_row_o) && $stable(total_matches_o) && $stable(end_of_run_o))
    else $error("result changed while stalled");

  a_total_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_total_o |-> end_of_run_o)
    else $error("total result without end of run");

  a_total_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_total_o |-> match_row_o == '0)
    else $error("total result carries a row index");

  a_match_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_total_o |-> total_matches_o == '0)
    else $error("match result carries a count");

endmodule

bind column_predicate_filter_top cpf_checker u_cpf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .is_total_o      (is_total_o),
  .match_row_o     (match_row_o),
  .total_matches_o (total_matches_o),
  .end_of_run_o    (end_of_run_o)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxRows = cpf_pkg::MaxRowsDefault;
  localparam int unsigned MatchCap =
      (MaxRows < cpf_pkg::CountMax) ? MaxRows : cpf_pkg::CountMax;
  localparam int SettleCycles = 10;
  localparam int CycleLimit = 200000;
  localparam logic signed [cpf_pkg::ValueW-1:0] MinVal = 32'sh8000_0000;
  localparam logic signed [cpf_pkg::ValueW-1:0] MaxVal = 32'sh7fff_ffff;
  localparam logic [cpf_pkg::CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [cpf_pkg::CfgIdxW-1:0] RegSpare3 = 2'd3;
  localparam logic [cpf_pkg::KindW-1:0] CmpSpare5 = 3'd5;
  localparam logic [cpf_pkg::KindW-1:0] CmpSpare6 = 3'd6;
  localparam logic [cpf_pkg::KindW-1:0] CmpSpare7 = 3'd7;

  typedef struct packed {
    logic signed [cpf_pkg::ValueW-1:0] value;
    logic                              deleted;
    logic                              last;
  } row_item_t;

  logic                              clk_i;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic signed [cpf_pkg::ValueW-1:0] row_value_i = '0;
  logic                              row_deleted_i = 1'b0;
  logic                              last_row_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b1;
  logic                              is_total_o;
  logic [cpf_pkg::RowIdxW-1:0]       match_row_o;
  logic [cpf_pkg::CountW-1:0]        total_matches_o;
  logic                              end_of_run_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [cpf_pkg::CfgIdxW-1:0]       cfg_index_i = '0;
  logic [cpf_pkg::ValueW-1:0]        cfg_data_i = '0;

  row_item_t        rows_to_send[$];
  cpf_pkg::result_t expected_results[$];
  row_item_t        drive_row;
  logic             row_taken = 1'b0;
  int unsigned      rows_queued = 0;
  int unsigned      rows_accepted = 0;
  int               send_idle_pct = 30;
  int               recv_idle_pct = 63;
  int               fail_count = 0;
  int               cycle_count = 0;

  logic [cpf_pkg::KindW-1:0]         filt_kind = '0;
  logic signed [cpf_pkg::ValueW-1:0] filt_target = '0;
  int unsigned                       row_index = 0;
  int unsigned                       match_total = 0;

  column_predicate_filter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .row_value_i     (row_value_i),
    .row_deleted_i   (row_deleted_i),
    .last_row_i      (last_row_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_total_o      (is_total_o),
    .match_row_o     (match_row_o),
    .total_matches_o (total_matches_o),
    .end_of_run_o    (end_of_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic row_passes(input logic signed [cpf_pkg::ValueW-1:0] v,
                                      input logic signed [cpf_pkg::ValueW-1:0] t,
                                      input logic [cpf_pkg::KindW-1:0] kind);
    case (kind)
      cpf_pkg::CMP_EQ: return v == t;
      cpf_pkg::CMP_GT: return v > t;
      cpf_pkg::CMP_GE: return v >= t;
      cpf_pkg::CMP_LT: return v < t;
      cpf_pkg::CMP_LE: return v <= t;
      default:         return 1'b0;
    endcase
  endfunction

  task automatic predict_row(input row_item_t row);
    cpf_pkg::result_t r;
    logic             hit;
    hit = !row.deleted && row_passes(row.value, filt_target, filt_kind);
    if (hit) begin
      r = '0;
      r.match_row = row_index[cpf_pkg::RowIdxW-1:0];
      r.end_of_run = !row.last;
      expected_results.push_back(r);
      if (match_total < MatchCap) match_total++;
    end
    if (row.last) begin
      r = '0;
      r.is_total = 1'b1;
      r.total_matches = match_total[cpf_pkg::CountW-1:0];
      r.end_of_run = 1'b1;
      expected_results.push_back(r);
      row_index = 0;
      match_total = 0;
    end else begin
      row_index++;
      if (row_index >= MaxRows) row_index = 0;
    end
  endtask

  task automatic check_result();
    cpf_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $error("result transfer with nothing expected: is_total %0d match_row %0d total %0d",
             is_total_o, match_row_o, total_matches_o);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (is_total_o !== want.is_total) begin
        $error("is_total expected %0d got %0d", want.is_total, is_total_o);
        fail_count++;
      end
      if (match_row_o !== want.match_row) begin
        $error("match_row expected %0d got %0d", want.match_row, match_row_o);
        fail_count++;
      end
      if (total_matches_o !== want.total_matches) begin
        $error("total_matches expected %0d got %0d", want.total_matches, total_matches_o);
        fail_count++;
      end
      if (end_of_run_o !== want.end_of_run) begin
        $error("end_of_run expected %0d got %0d", want.end_of_run, end_of_run_o);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      row_taken <= rst_ni && in_valid_i && !in_stall_o;
      if (rst_ni) begin
        if (cfg_valid_i && cfg_ready_o) begin
          case (cfg_index_i)
            cpf_pkg::REG_COMPARE_KIND: filt_kind = cfg_data_i[cpf_pkg::KindW-1:0];
            cpf_pkg::REG_TARGET_VALUE: filt_target = cfg_data_i;
            default: ;
          endcase
        end
        if (in_valid_i && !in_stall_o) begin
          predict_row('{row_value_i, row_deleted_i, last_row_i});
          rows_accepted++;
        end
        if (out_valid_o && !out_stall_i) check_result();
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || row_taken) begin
      if (rows_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_row = rows_to_send.pop_front();
        in_valid_i <= 1'b1;
        row_value_i <= drive_row.value;
        row_deleted_i <= drive_row.deleted;
        last_row_i <= drive_row.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic push_row(input logic signed [cpf_pkg::ValueW-1:0] v, input logic del,
                          input logic lst);
    rows_to_send.push_back('{v, del, lst});
    rows_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (rows_accepted != rows_queued || expected_results.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [cpf_pkg::CfgIdxW-1:0] idx,
                           input logic [cpf_pkg::ValueW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [cpf_pkg::ValueW-1:0] pick_target();
    case ($urandom_range(5))
      0:       return MinVal;
      1:       return MaxVal;
      2:       return '0;
      3:       return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [cpf_pkg::ValueW-1:0] pick_value(
      input logic signed [cpf_pkg::ValueW-1:0] tgt);
    case ($urandom_range(6))
      0, 1:    return tgt + ($urandom_range(4) - 2);
      2:       return MinVal;
      3:       return MaxVal;
      4:       return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int n_items);
    int                                sent;
    int                                blk_len;
    logic                              lst;
    logic [cpf_pkg::KindW-1:0]         kind;
    logic [cpf_pkg::ValueW-1:0]        kdata;
    logic signed [cpf_pkg::ValueW-1:0] tgt;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? RegSpare2 : RegSpare3, $urandom);
      if ($urandom_range(9) == 0)
        kind = cpf_pkg::KindW'($urandom_range(int'(CmpSpare7), int'(CmpSpare5)));
      else kind = cpf_pkg::KindW'($urandom_range(int'(cpf_pkg::CMP_LE)));
      kdata = $urandom;
      kdata[cpf_pkg::KindW-1:0] = kind;
      tgt = pick_target();
      if ($urandom_range(1)) begin
        write_reg(cpf_pkg::REG_COMPARE_KIND, kdata);
        write_reg(cpf_pkg::REG_TARGET_VALUE, tgt);
      end else begin
        write_reg(cpf_pkg::REG_TARGET_VALUE, tgt);
        write_reg(cpf_pkg::REG_COMPARE_KIND, kdata);
      end
      repeat (4) begin
        blk_len = $urandom_range(16, 1);
        for (int r = 0; r < blk_len; r++) begin
          lst = (r == blk_len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(24) == 0);
          push_row(pick_value(tgt), $urandom_range(4) == 0, lst);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: equal to zero
    push_row('0, 1'b0, 1'b0);
    push_row('0, 1'b1, 1'b0);
    push_row(-1, 1'b0, 1'b0);
    push_row(MaxVal, 1'b0, 1'b0);
    push_row(MinVal, 1'b0, 1'b0);
    push_row('0, 1'b0, 1'b1);
    wait_idle();

    // true greater-or-equal at the minimum, deleted last row
    write_reg(cpf_pkg::REG_COMPARE_KIND, 32'(cpf_pkg::CMP_GE));
    write_reg(cpf_pkg::REG_TARGET_VALUE, MinVal);
    push_row(MinVal, 1'b0, 1'b0);
    push_row(MaxVal, 1'b0, 1'b0);
    push_row(MinVal, 1'b1, 1'b1);
    wait_idle();

    write_reg(cpf_pkg::REG_COMPARE_KIND, 32'(cpf_pkg::CMP_GT));
    write_reg(cpf_pkg::REG_TARGET_VALUE, MaxVal);
    push_row(MaxVal, 1'b0, 1'b0);
    push_row(MinVal, 1'b0, 1'b1);
    wait_idle();

    write_reg(cpf_pkg::REG_TARGET_VALUE, MinVal);
    push_row(MinVal, 1'b0, 1'b0);
    push_row(MinVal + 1, 1'b0, 1'b1);
    wait_idle();

    write_reg(cpf_pkg::REG_COMPARE_KIND, 32'(cpf_pkg::CMP_LT));
    push_row(MinVal, 1'b0, 1'b1);
    wait_idle();

    write_reg(cpf_pkg::REG_COMPARE_KIND, 32'(cpf_pkg::CMP_LE));
    write_reg(cpf_pkg::REG_TARGET_VALUE, MaxVal);
    push_row(MaxVal, 1'b0, 1'b0);
    push_row(MinVal, 1'b0, 1'b1);
    wait_idle();

    // unused compare codes never match
    write_reg(cpf_pkg::REG_TARGET_VALUE, '0);
    write_reg(cpf_pkg::REG_COMPARE_KIND, {29'h1fff_ffff, CmpSpare5});
    push_row('0, 1'b0, 1'b1);
    wait_idle();
    write_reg(cpf_pkg::REG_COMPARE_KIND, 32'(CmpSpare6));
    push_row('0, 1'b0, 1'b1);
    wait_idle();
    write_reg(cpf_pkg::REG_COMPARE_KIND, 32'(CmpSpare7));
    push_row('0, 1'b0, 1'b1);
    wait_idle();

    // writes to spare indexes leave both registers alone
    write_reg(cpf_pkg::REG_COMPARE_KIND, 32'(cpf_pkg::CMP_EQ));
    write_reg(RegSpare2, 32'hffff_ffff);
    write_reg(RegSpare3, 32'h1234_5679);
    push_row('0, 1'b0, 1'b1);

    run_random(180);

    send_idle_pct = 63;
    recv_idle_pct = 30;
    run_random(180);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(180);

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
